[src/hbch_pkg.sv]
// Shared widths, limits and operation codes for the hash bucket collision histogram.
`timescale 1ns / 1ps
package hbch_pkg;
  localparam int KEY_W = 31;
  localparam int CFG_W = 7;
  localparam int CNT_W = 16;
  localparam int BIDX_W = 6;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REPORT = 1'b1;
  typedef logic [CNT_W-1:0] cnt_t;
endpackage

[src/hbch_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module hbch_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

[src/hash_bucket_collision_histogram.sv]
// Top level of the hash bucket collision histogram with its divider and scan sequencer.
//
// Usage: an input word with in_func insert hashes in_key to bucket
// in_key mod bucket_count and either marks the bucket occupied or counts one
// more collision there, saturating at the count maximum. An input word with
// in_func report emits, in ascending order, the index of every bucket that
// holds the greatest collision count, with out_last on the final one.
// An insert is accepted, runs a bit-serial remainder loop over the key bits,
// reads the count memory and writes it back. A report runs a maximum scan
// over the buckets in use and then an emit pass up to the last match, longer
// if the receiver stalls. Only one input word is in flight; in_stall is
// high while it runs. A result waits in the output register while out_stall
// is high, and the emit pass holds until the register is free.
// Reset clears all occupied marks at once, so all counts read as zero, and sets
// bucket_count to 64. cfg_wr_en writes bucket_count; a value of 0 acts as 1 and
// values above MAX_BUCKETS act as MAX_BUCKETS. The store is kept across writes.
`timescale 1ns / 1ps
module hash_bucket_collision_histogram import hbch_pkg::*; #(
  parameter int MAX_BUCKETS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_func,
  input  logic [KEY_W-1:0]  in_key,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BIDX_W-1:0] out_bucket_index,
  output logic              out_last
);
  localparam int IDX_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int DIV_STEPS = KEY_W;
  localparam int STEP_W = $clog2(DIV_STEPS);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DIV      = 3'd1;
  localparam logic [2:0] S_INS_RD   = 3'd2;
  localparam logic [2:0] S_INS_WR   = 3'd3;
  localparam logic [2:0] S_SCAN_RD  = 3'd4;
  localparam logic [2:0] S_SCAN_CMP = 3'd5;
  localparam logic [2:0] S_EMIT_RD  = 3'd6;
  localparam logic [2:0] S_EMIT_CMP = 3'd7;

  logic [2:0]              state_r, state_nxt;
  logic [CFG_W-1:0]        bucket_count_r, bucket_count_nxt;
  logic [CFG_W-1:0]        m_eff;
  logic [KEY_W-1:0]        key_r, key_nxt;
  logic [CFG_W-1:0]        rem_r, rem_nxt;
  logic [CFG_W:0]          trial;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [IDX_W-1:0]        last_hit_r, last_hit_nxt;
  cnt_t                    best_r, best_nxt;
  logic [MAX_BUCKETS-1:0]  occ_r, occ_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [BIDX_W-1:0]       out_idx_r, out_idx_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    ram_we, ram_re;
  cnt_t                    ram_wdata, ram_rdata, val;
  logic                    at_end, out_free;

  always_comb begin
    if (bucket_count_r == '0) begin
      m_eff = CFG_W'(1);
    end else if (bucket_count_r > CFG_W'(MAX_BUCKETS)) begin
      m_eff = CFG_W'(MAX_BUCKETS);
    end else begin
      m_eff = bucket_count_r;
    end
  end

  assign trial = {rem_r, key_r[KEY_W-1]};
  always_comb begin
    if (trial >= {1'b0, m_eff}) begin
      rem_nxt = CFG_W'(trial - {1'b0, m_eff});
    end else begin
      rem_nxt = CFG_W'(trial);
    end
  end

  assign val = occ_r[idx_r] ? ram_rdata : '0;
  assign at_end = (CFG_W'(idx_r) == m_eff - CFG_W'(1));
  assign out_free = !out_valid_r || !out_stall;
  assign ram_re = (state_r == S_INS_RD) || (state_r == S_SCAN_RD) || (state_r == S_EMIT_RD);
  assign ram_we = (state_r == S_INS_WR);
  always_comb begin
    if (!occ_r[idx_r]) begin
      ram_wdata = '0;
    end else if (ram_rdata == CNT_MAX) begin
      ram_wdata = CNT_MAX;
    end else begin
      ram_wdata = ram_rdata + cnt_t'(1);
    end
  end

  hbch_ram #(
    .WIDTH(CNT_W),
    .DEPTH(MAX_BUCKETS),
    .AW(IDX_W)
  ) u_count_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(idx_r),
    .wdata(ram_wdata),
    .re(ram_re),
    .raddr(idx_r),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    bucket_count_nxt = cfg_wr_en ? cfg_wr_data : bucket_count_r;
    key_nxt = key_r;
    step_nxt = step_r;
    idx_nxt = idx_r;
    last_hit_nxt = last_hit_r;
    best_nxt = best_r;
    occ_nxt = occ_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_idx_nxt = out_idx_r;
    out_last_nxt = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_func == FUNC_INSERT) begin
            key_nxt = in_key;
            step_nxt = '0;
            state_nxt = S_DIV;
          end else begin
            idx_nxt = '0;
            best_nxt = '0;
            last_hit_nxt = '0;
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_DIV: begin
        key_nxt = key_r << 1;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          idx_nxt = rem_nxt[IDX_W-1:0];
          state_nxt = S_INS_RD;
        end
      end
      S_INS_RD: begin
        state_nxt = S_INS_WR;
      end
      S_INS_WR: begin
        occ_nxt[idx_r] = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (val > best_r) begin
          best_nxt = val;
          last_hit_nxt = idx_r;
        end else if (val == best_r) begin
          last_hit_nxt = idx_r;
        end
        if (at_end) begin
          idx_nxt = '0;
          state_nxt = S_EMIT_RD;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
          state_nxt = S_SCAN_RD;
        end
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_CMP;
      end
      S_EMIT_CMP: begin
        if (val != best_r) begin
          idx_nxt = idx_r + IDX_W'(1);
          state_nxt = S_EMIT_RD;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt = BIDX_W'(idx_r);
          out_last_nxt = (idx_r == last_hit_r);
          if (idx_r == last_hit_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bucket_count_r <= CFG_W'(64);
      occ_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bucket_count_r <= bucket_count_nxt;
      occ_r <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    step_r <= step_nxt;
    idx_r <= idx_nxt;
    last_hit_r <= last_hit_nxt;
    best_r <= best_nxt;
    out_idx_r <= out_idx_nxt;
    out_last_r <= out_last_nxt;
    if (state_r == S_IDLE) begin
      rem_r <= '0;
    end else if (state_r == S_DIV) begin
      rem_r <= rem_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_bucket_index = out_idx_r;
  assign out_last = out_last_r;

  a_rem_below_modulus: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < m_eff))
    else $error("Remainder reached the modulus.");

  a_emit_not_above_best: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT_CMP) |-> (val <= best_r))
    else $error("Emit pass found a count above the scanned maximum.");

  a_emit_stops_at_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT_RD) |-> (idx_r <= last_hit_r))
    else $error("Emit pass ran past the last matching bucket.");

  a_occ_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(occ_r) >= $past($countones(occ_r))))
    else $error("An occupied mark was lost.");
endmodule
